FILE: design/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache lookup.
package sacl_pkg;

    localparam int SETS_DEF       = 256;
    localparam int WAYS_DEF       = 8;
    localparam int ADDR_WIDTH_DEF = 24;
    localparam int AGE_WIDTH_DEF  = 16;

    localparam int MAX_INDEX_BITS = 8;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int COUNT_W        = 32;
    localparam int WAY_OUT_W      = 3;
    localparam int SET_OUT_W      = 8;
    localparam int OFF_OUT_W      = 7;
    localparam int M_TUSER_W      = 5;

    localparam logic [2:0] OFFSET_BITS_RST  = 3'd5;
    localparam logic [3:0] INDEX_BITS_RST   = 4'd8;
    localparam logic [3:0] WAYS_IN_USE_RST  = 4'd4;
    localparam logic       COUNT_WRITES_RST = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OFFSET_BITS  = 2'd0,
        CFG_INDEX_BITS   = 2'd1,
        CFG_WAYS_IN_USE  = 2'd2,
        CFG_COUNT_WRITES = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_WRITE = 2'd1,
        UPD_FILL  = 2'd2
    } upd_kind_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic lookup;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/sacl_ram.sv
// Generic simple dual-port RAM with registered read.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sacl_ctrl.sv
// Sequencer: clearing pass, then accept / lookup / write-back per request.
module sacl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  sacl_pkg::dp_status_t  status,
    output sacl_pkg::ctl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd.clear  = (state_reg == ST_CLEAR);
        cmd.accept = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.lookup = (state_reg == ST_LOOKUP);
        cmd.commit = (state_reg == ST_WRITE) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_axis_tready = s_ready_reg;

endmodule

FILE: design/sacl_dp.sv
// Datapath: config registers, address split, set row memory, LRU update, totals.
module sacl_dp #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF,
    parameter int AGE_WIDTH  = sacl_pkg::AGE_WIDTH_DEF,
    localparam int S_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int M_RAW_W   = 2 * sacl_pkg::WAY_OUT_W + ADDR_WIDTH + sacl_pkg::SET_OUT_W
                               + sacl_pkg::OFF_OUT_W + 3 * sacl_pkg::COUNT_W,
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sacl_pkg::ctl_cmd_t                  cmd,
    output sacl_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [sacl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [S_TDATA_W-1:0]                s_axis_tdata,
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [M_TDATA_W-1:0]                m_axis_tdata,
    output logic [sacl_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W  = $clog2(WAYS + 1);
    localparam int TAGS_W = WAYS * ADDR_WIDTH;
    localparam int AGES_W = WAYS * AGE_WIDTH;
    localparam int ROW_W  = TAGS_W + AGES_W + WAYS;
    localparam int MAP_W  = 256 * SET_W;

    function automatic logic [MAP_W-1:0] build_set_map();
        logic [MAP_W-1:0] m;
        m = '0;
        for (int i = 0; i < 256; i++) begin
            m[i*SET_W +: SET_W] = SET_W'(i % SETS);
        end
        return m;
    endfunction

    localparam logic [MAP_W-1:0] SET_MAP = build_set_map();

    // configuration
    logic [2:0] ob_reg;
    logic [3:0] ib_reg;
    logic [3:0] ways_reg;
    logic       cw_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_reg    <= sacl_pkg::OFFSET_BITS_RST;
            ib_reg    <= sacl_pkg::INDEX_BITS_RST;
            ways_reg  <= sacl_pkg::WAYS_IN_USE_RST;
            cw_en_reg <= sacl_pkg::COUNT_WRITES_RST;
        end else if (cfg_we) begin
            unique case (sacl_pkg::cfg_idx_t'(cfg_addr))
                sacl_pkg::CFG_OFFSET_BITS:  ob_reg    <= cfg_wdata[2:0];
                sacl_pkg::CFG_INDEX_BITS:   ib_reg    <= cfg_wdata[3:0];
                sacl_pkg::CFG_WAYS_IN_USE:  ways_reg  <= cfg_wdata[3:0];
                sacl_pkg::CFG_COUNT_WRITES: cw_en_reg <= cfg_wdata[0];
            endcase
        end
    end

    // address split
    logic [ADDR_WIDTH-1:0] s_addr;
    logic [3:0]            ib_eff;
    logic [3:0]            shift_c;
    logic [7:0]            set8_c;
    logic [SET_W-1:0]      set_c;
    logic [7:0]            set_mask_c;
    logic [6:0]            off_mask_c;
    logic [NW_W-1:0]       nw_c;

    assign s_addr = s_axis_tdata[ADDR_WIDTH-1:0];
    assign set_c  = SET_MAP[32'(set8_c) * SET_W +: SET_W];

    always_comb begin
        ib_eff     = (ib_reg > 4'(sacl_pkg::MAX_INDEX_BITS)) ?
                     4'(sacl_pkg::MAX_INDEX_BITS) : ib_reg;
        shift_c    = 4'(ob_reg) + ib_eff;
        set_mask_c = 8'((16'd1 << ib_eff) - 16'd1);
        off_mask_c = 7'((8'd1 << ob_reg) - 8'd1);
        set8_c     = 8'(s_addr >> ob_reg) & set_mask_c;
        if (ways_reg == 4'd0) begin
            nw_c = NW_W'(1);
        end else if (32'(ways_reg) > WAYS) begin
            nw_c = NW_W'(WAYS);
        end else begin
            nw_c = NW_W'(ways_reg);
        end
    end

    // captured request
    logic                  mode_reg;
    logic                  cw_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [SET_W-1:0]      set_addr_reg;
    logic [6:0]            off_reg;
    logic [NW_W-1:0]       nw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg     <= s_axis_tuser;
            cw_reg       <= s_axis_tuser & cw_en_reg;
            tag_reg      <= s_addr >> shift_c;
            set_addr_reg <= set_c;
            off_reg      <= 7'(s_addr) & off_mask_c;
            nw_reg       <= nw_c;
        end
    end

    // set row memory
    logic [SET_W-1:0] clr_idx_reg;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] new_row;
    logic             ram_wr_en;
    logic [SET_W-1:0] ram_wr_addr;
    logic [ROW_W-1:0] ram_wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear) begin
            clr_idx_reg <= clr_idx_reg + SET_W'(1);
        end
    end

    assign status.clear_last = (clr_idx_reg == SET_W'(SETS - 1));

    assign ram_wr_en   = cmd.clear | cmd.commit;
    assign ram_wr_addr = cmd.clear ? clr_idx_reg : set_addr_reg;
    assign ram_wr_data = cmd.clear ? '0 : new_row;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (set_c),
        .rd_data (rd_row)
    );

    logic [ADDR_WIDTH-1:0] rd_tag [WAYS];
    logic [AGE_WIDTH-1:0]  rd_age [WAYS];
    logic [WAYS-1:0]       rd_valid;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            rd_tag[w] = rd_row[w*ADDR_WIDTH +: ADDR_WIDTH];
            rd_age[w] = rd_row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH];
        end
        rd_valid = rd_row[TAGS_W + AGES_W +: WAYS];
    end

    // lookup: tag match and first least-aged way
    logic             hit_c;
    logic [WAY_W-1:0] hit_way_c;
    logic [WAY_W-1:0] victim_c;
    logic [AGE_WIDTH-1:0] best_age;
    logic             hit_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic [WAY_W-1:0] victim_reg;

    always_comb begin
        hit_c     = 1'b0;
        hit_way_c = '0;
        victim_c  = '0;
        best_age  = rd_age[0];
        for (int w = 0; w < WAYS; w++) begin
            if (NW_W'(w) < nw_reg && rd_valid[w] && rd_tag[w] == tag_reg && !hit_c) begin
                hit_c     = 1'b1;
                hit_way_c = WAY_W'(w);
            end
            if (w > 0 && NW_W'(w) < nw_reg && rd_age[w] < best_age) begin
                best_age = rd_age[w];
                victim_c = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg     <= hit_c;
            hit_way_reg <= hit_way_c;
            victim_reg  <= victim_c;
        end
    end

    // write-back row
    logic                 upd_en;
    logic [WAY_W-1:0]     upd_way;
    logic [AGE_WIDTH-1:0] age0;
    sacl_pkg::upd_kind_t  kind_c;

    assign upd_en  = !hit_reg || cw_reg;
    assign upd_way = hit_reg ? hit_way_reg : victim_reg;

    always_comb begin
        if (!hit_reg) begin
            kind_c = sacl_pkg::UPD_FILL;
        end else if (cw_reg) begin
            kind_c = sacl_pkg::UPD_WRITE;
        end else begin
            kind_c = sacl_pkg::UPD_NONE;
        end
    end

    always_comb begin
        new_row = rd_row;
        age0    = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (NW_W'(w) < nw_reg) begin
                // the hit or filled way restarts at zero; it then ages only on a hit without a counted write
                age0 = (WAY_W'(w) == upd_way) ? '0 : rd_age[w];
                if (upd_en && WAY_W'(w) == upd_way) begin
                    new_row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH] = '0;
                end else if (age0 != '1) begin
                    new_row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH] = age0 + AGE_WIDTH'(1);
                end else begin
                    new_row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH] = age0;
                end
                if (!hit_reg && WAY_W'(w) == victim_reg) begin
                    new_row[w*ADDR_WIDTH +: ADDR_WIDTH] = tag_reg;
                    new_row[TAGS_W + AGES_W + w]        = 1'b1;
                end
            end
        end
    end

    // totals and result register
    logic [sacl_pkg::COUNT_W-1:0]   hits_total_reg;
    logic [sacl_pkg::COUNT_W-1:0]   misses_total_reg;
    logic [sacl_pkg::COUNT_W-1:0]   writes_total_reg;
    logic                           m_valid_reg;
    logic                           hit_out_reg;
    logic [sacl_pkg::WAY_OUT_W-1:0] hit_way_out_reg;
    sacl_pkg::upd_kind_t            kind_out_reg;
    logic [sacl_pkg::WAY_OUT_W-1:0] upd_way_out_reg;
    logic [ADDR_WIDTH-1:0]          tag_out_reg;
    logic [sacl_pkg::SET_OUT_W-1:0] set_out_reg;
    logic [sacl_pkg::OFF_OUT_W-1:0] off_out_reg;
    logic                           mem_read_out_reg;
    logic                           mem_write_out_reg;

    assign status.out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_total_reg   <= '0;
            misses_total_reg <= '0;
            writes_total_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (hit_reg) begin
                    hits_total_reg <= hits_total_reg + sacl_pkg::COUNT_W'(1);
                end else begin
                    misses_total_reg <= misses_total_reg + sacl_pkg::COUNT_W'(1);
                end
                if (cw_reg) begin
                    writes_total_reg <= writes_total_reg + sacl_pkg::COUNT_W'(1);
                end
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_out_reg       <= hit_reg;
            hit_way_out_reg   <= hit_reg ? sacl_pkg::WAY_OUT_W'(hit_way_reg) : '0;
            kind_out_reg      <= kind_c;
            upd_way_out_reg   <= upd_en ? sacl_pkg::WAY_OUT_W'(upd_way) : '0;
            tag_out_reg       <= tag_reg;
            set_out_reg       <= sacl_pkg::SET_OUT_W'(set_addr_reg);
            off_out_reg       <= off_reg;
            mem_read_out_reg  <= !mode_reg;
            mem_write_out_reg <= cw_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({writes_total_reg, misses_total_reg, hits_total_reg,
                                       off_out_reg, set_out_reg, tag_out_reg,
                                       upd_way_out_reg, hit_way_out_reg});
    assign m_axis_tuser  = {mem_write_out_reg, mem_read_out_reg, kind_out_reg, hit_out_reg};

endmodule

FILE: design/set_assoc_cache_lru_lookup_top.sv
// Top level of the set-associative cache lookup with LRU replacement.
// Each request reads one set row (tags, ages, valid bits of all ways) from a
// single row memory, selects the hit or victim way, and writes the row back,
// in the steps read, lookup, write-back; write-back waits while the result
// register holds a result not yet taken on m_axis_tready. After reset a clearing
// pass writes every row once before s_axis_tready rises; config writes are taken
// during it. Result counts are the totals after the request.
module set_assoc_cache_lru_lookup_top #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH = sacl_pkg::ADDR_WIDTH_DEF,
    parameter int AGE_WIDTH  = sacl_pkg::AGE_WIDTH_DEF,
    localparam int S_TDATA_W = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int M_RAW_W   = 2 * sacl_pkg::WAY_OUT_W + ADDR_WIDTH + sacl_pkg::SET_OUT_W
                               + sacl_pkg::OFF_OUT_W + 3 * sacl_pkg::COUNT_W,
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sacl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,  // address
    input  logic                            s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_way, updated_way, tag, set_index, block_offset,
    // hit_count, miss_count, mem_write_count
    output logic [M_TDATA_W-1:0]            m_axis_tdata,
    // hit, update_kind, mem_read, mem_write
    output logic [sacl_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    sacl_pkg::ctl_cmd_t   cmd;
    sacl_pkg::dp_status_t status;

    sacl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sacl_dp #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .AGE_WIDTH  (AGE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: tb/sv/sacl_lookup_check.sv
`timescale 1ns / 100ps
// Checker for the cache lookup: mirrors the cache state and compares every result.
module sacl_lookup_check #(
    parameter int M_W = 144
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sacl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [M_W-1:0]                  m_tdata,
    input  logic [sacl_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                              mismatches,
    output int                              in_flight
);
    import sacl_pkg::*;

    localparam int NSETS = SETS_DEF;
    localparam int NWAYS = WAYS_DEF;
    localparam logic [15:0] AGE_SAT = 16'hFFFF;

    typedef struct packed {
        logic        hit;
        logic [2:0]  hit_way;
        upd_kind_t   kind;
        logic [2:0]  upd_way;
        logic [23:0] tag;
        logic [7:0]  set_idx;
        logic [6:0]  offset;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] writes;
    } lookup_t;

    logic [23:0] line_tag   [0:NSETS-1][0:NWAYS-1];
    logic        line_valid [0:NSETS-1][0:NWAYS-1];
    logic [15:0] line_age   [0:NSETS-1][0:NWAYS-1];
    logic [31:0] hits_n, misses_n, writes_n;
    logic [2:0]  cfg_ob;
    logic [3:0]  cfg_ib;
    logic [3:0]  cfg_ways;
    logic        cfg_cw;

    lookup_t lookup_q [$];
    lookup_t want_r, got_r;
    int      si, wi;
    int      n_results;

    task automatic predict_access(input logic wr, input logic [23:0] addr,
                                  output lookup_t res);
        int unsigned a, ib, nw, tg, st, off, w, victim;
        logic found, cw;
        res = '0;
        a = 32'(addr);
        ib = (32'(cfg_ib) > MAX_INDEX_BITS) ? MAX_INDEX_BITS : 32'(cfg_ib);
        nw = (cfg_ways == 0) ? 1 : ((32'(cfg_ways) > NWAYS) ? NWAYS : 32'(cfg_ways));
        tg = a >> (ib + cfg_ob);
        st = (a >> cfg_ob) & ((32'd1 << ib) - 1);
        off = a & ((32'd1 << cfg_ob) - 1);
        cw = wr & cfg_cw;
        found = 1'b0;
        for (w = 0; w < nw; w++) begin
            if (!found && line_valid[st][w] && line_tag[st][w] == tg[23:0]) begin
                found = 1'b1;
                res.hit_way = w[2:0];
            end
        end
        res.hit = found;
        res.kind = UPD_NONE;
        if (found) begin
            hits_n = hits_n + 1;
            line_age[st][res.hit_way] = '0;
            if (cw) begin
                res.kind = UPD_WRITE;
                res.upd_way = res.hit_way;
            end
        end else begin
            misses_n = misses_n + 1;
            victim = 0;
            for (w = 1; w < nw; w++) begin
                if (line_age[st][w] < line_age[st][victim])
                    victim = w;
            end
            line_tag[st][victim] = tg[23:0];
            line_valid[st][victim] = 1'b1;
            line_age[st][victim] = '0;
            res.kind = UPD_FILL;
            res.upd_way = victim[2:0];
        end
        if (cw)
            writes_n = writes_n + 1;
        // every way but the one just written ages, saturating
        for (w = 0; w < nw; w++) begin
            if (!(res.kind != UPD_NONE && w == res.upd_way) && line_age[st][w] != AGE_SAT)
                line_age[st][w] = line_age[st][w] + 16'd1;
        end
        res.tag = tg[23:0];
        res.set_idx = st[7:0];
        res.offset = off[6:0];
        res.mem_read = !wr;
        res.mem_write = cw;
        res.hits = hits_n;
        res.misses = misses_n;
        res.writes = writes_n;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch result %0d %s: got %0h want %0h", n_results, what, got, want);
        mismatches++;
    endtask

    task automatic compare_result(input lookup_t got, input lookup_t want);
        if (got.hit !== want.hit)
            report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_way !== want.hit_way)
            report_mismatch("hit_way", 32'(got.hit_way), 32'(want.hit_way));
        if (got.kind !== want.kind)
            report_mismatch("update_kind", 32'(got.kind), 32'(want.kind));
        if (got.upd_way !== want.upd_way)
            report_mismatch("updated_way", 32'(got.upd_way), 32'(want.upd_way));
        if (got.tag !== want.tag)
            report_mismatch("tag", 32'(got.tag), 32'(want.tag));
        if (got.set_idx !== want.set_idx)
            report_mismatch("set_index", 32'(got.set_idx), 32'(want.set_idx));
        if (got.offset !== want.offset)
            report_mismatch("block_offset", 32'(got.offset), 32'(want.offset));
        if (got.mem_read !== want.mem_read)
            report_mismatch("mem_read", 32'(got.mem_read), 32'(want.mem_read));
        if (got.mem_write !== want.mem_write)
            report_mismatch("mem_write", 32'(got.mem_write), 32'(want.mem_write));
        if (got.hits !== want.hits)
            report_mismatch("hit_count", got.hits, want.hits);
        if (got.misses !== want.misses)
            report_mismatch("miss_count", got.misses, want.misses);
        if (got.writes !== want.writes)
            report_mismatch("mem_write_count", got.writes, want.writes);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (si = 0; si < NSETS; si++) begin
                for (wi = 0; wi < NWAYS; wi++) begin
                    line_tag[si][wi] = '0;
                    line_valid[si][wi] = 1'b0;
                    line_age[si][wi] = '0;
                end
            end
            hits_n = '0;
            misses_n = '0;
            writes_n = '0;
            cfg_ob = OFFSET_BITS_RST;
            cfg_ib = INDEX_BITS_RST;
            cfg_ways = WAYS_IN_USE_RST;
            cfg_cw = COUNT_WRITES_RST;
            lookup_q.delete();
            mismatches = 0;
            in_flight = 0;
            n_results = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OFFSET_BITS:  cfg_ob = cfg_wdata[2:0];
                    CFG_INDEX_BITS:   cfg_ib = cfg_wdata;
                    CFG_WAYS_IN_USE:  cfg_ways = cfg_wdata;
                    CFG_COUNT_WRITES: cfg_cw = cfg_wdata[0];
                    default: ;
                endcase
            end
            // results first: a request accepted on this edge cannot have answered yet
            if (m_tvalid && m_tready) begin
                got_r = '0;
                got_r.hit_way = m_tdata[2:0];
                got_r.upd_way = m_tdata[5:3];
                got_r.tag = m_tdata[29:6];
                got_r.set_idx = m_tdata[37:30];
                got_r.offset = m_tdata[44:38];
                got_r.hits = m_tdata[76:45];
                got_r.misses = m_tdata[108:77];
                got_r.writes = m_tdata[140:109];
                got_r.hit = m_tuser[0];
                got_r.kind = upd_kind_t'(m_tuser[2:1]);
                got_r.mem_read = m_tuser[3];
                got_r.mem_write = m_tuser[4];
                if (lookup_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got_r.tag), 32'd0);
                end else begin
                    want_r = lookup_q.pop_front();
                    compare_result(got_r, want_r);
                end
                n_results++;
            end
            if (s_tvalid && s_tready) begin
                predict_access(s_tuser, s_tdata, want_r);
                lookup_q.push_back(want_r);
            end
            in_flight = lookup_q.size();
        end
    end

endmodule

FILE: tb/sv/set_assoc_cache_lru_lookup_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the cache lookup: drives requests, config and back-pressure.
module set_assoc_cache_lru_lookup_top_test;
    import sacl_pkg::*;

    localparam int  M_W         = 144;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HOLD_CYCLES = 400;
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_W-1:0]        m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    int   mismatches, in_flight;
    int   cycles = 0;
    int   snd_idle_pct = 27;
    int   rcv_idle_pct = 68;
    logic hold_rcv = 1'b0;
    event hold_ev;

    int          cur_ob = 5;
    int          cur_ib = 8;
    logic [23:0] pool_tag [0:15];
    logic [7:0]  pool_set [0:2];

    set_assoc_cache_lru_lookup_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sacl_lookup_check #(.M_W(M_W)) check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_rcv)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    initial begin
        forever begin
            @(hold_ev);
            hold_rcv <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_rcv <= 1'b0;
        end
    end

    task automatic send_request(input logic mode, input logic [23:0] addr);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr;
        s_axis_tuser <= mode;
        forever begin
            @(negedge aclk);
            if (s_axis_tready)
                break;
        end
        @(posedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (in_flight != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic refill_pool();
        int i;
        for (i = 0; i < 16; i++)
            pool_tag[i] = 24'($urandom);
        for (i = 0; i < 3; i++)
            pool_set[i] = 8'($urandom);
    endtask

    task automatic new_phase(input logic [2:0] ob, input logic [3:0] ib,
                             input logic [3:0] ways, input logic cw);
        drain();
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_OFFSET_BITS;
        cfg_wdata <= {1'b0, ob};
        @(posedge aclk);
        cfg_addr <= CFG_INDEX_BITS;
        cfg_wdata <= ib;
        @(posedge aclk);
        cfg_addr <= CFG_WAYS_IN_USE;
        cfg_wdata <= ways;
        @(posedge aclk);
        cfg_addr <= CFG_COUNT_WRITES;
        cfg_wdata <= {3'b000, cw};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_ob = ob;
        cur_ib = (ib > MAX_INDEX_BITS) ? MAX_INDEX_BITS : ib;
        refill_pool();
    endtask

    // mostly a small pool of tags over a few sets so hits and evictions happen
    function automatic logic [23:0] next_addr();
        int unsigned a, tg, st, off;
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom);
        tg = pool_tag[$urandom_range(0, 15)];
        st = pool_set[$urandom_range(0, 2)] & ((32'd1 << cur_ib) - 1);
        off = $urandom & ((32'd1 << cur_ob) - 1);
        a = (tg << (cur_ib + cur_ob)) | (st << cur_ob) | off;
        return a[23:0];
    endfunction

    task automatic send_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_request(1'($urandom_range(0, 1)), next_addr());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: 32-byte blocks, 256 sets, 4 ways, writes counted
        send_request(MODE_READ,  24'h000000);
        send_request(MODE_READ,  24'h00001F);
        send_request(MODE_WRITE, 24'h000000);
        // second miss in the set replaces way 0 although other ways are invalid
        send_request(MODE_READ,  24'h002000);
        send_request(MODE_READ,  24'h000000);
        send_request(MODE_WRITE, 24'hFFFFFF);
        send_request(MODE_READ,  24'hFFFFFF);
        send_request(MODE_WRITE, 24'hFFFFE0);
        send_request(MODE_WRITE, 24'h002020);
        send_request(MODE_WRITE, 24'h004020);
        send_request(MODE_WRITE, 24'h006020);
        send_request(MODE_WRITE, 24'h008020);
        send_request(MODE_WRITE, 24'h00A020);
        send_request(MODE_READ,  24'h800020);
        send_request(MODE_READ,  24'h002020);

        // single set, single way, writes not counted
        new_phase(3'd0, 4'd0, 4'd1, 1'b0);
        send_request(MODE_WRITE, 24'h123456);
        send_request(MODE_WRITE, 24'h123456);
        send_random(200);
        new_phase(3'd7, 4'd8, 4'd8, 1'b1);
        send_random(200);

        snd_idle_pct = 68;
        rcv_idle_pct <= 27;
        // index width above the maximum, zero ways
        new_phase(3'd3, 4'd15, 4'd0, 1'b1);
        send_random(200);
        new_phase(3'd2, 4'd4, 4'd15, 1'b0);
        send_random(200);

        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        new_phase(3'd5, 4'd2, 4'd3, 1'b1);
        send_random(40);
        -> hold_ev;
        send_random(160);
        new_phase(3'd7, 4'd0, 4'd8, 1'b0);
        send_random(100);
        drain();
        send_random(100);

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_ctrl.sv
design/sacl_dp.sv
design/set_assoc_cache_lru_lookup_top.sv
tb/sv/sacl_lookup_check.sv
tb/sv/set_assoc_cache_lru_lookup_top_test.sv
